// ----- hdl/gmdfs_pkg.sv -----
// shared types and constants of the grid maze depth-first search unit
// no dependencies; every other file takes names from here by scope
package gmdfs_pkg;

	// grid geometry; the side is a power of two, so a cell index is {row, col}
	localparam int GRID_SIZE  = 8;
	localparam int ROW_W      = $clog2(GRID_SIZE);
	localparam int CELL_W     = 2 * ROW_W;
	localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE;
	localparam int DEPTH_W    = CELL_W + 1;

	// popped-cell counter
	localparam int               CNT_W   = 7;
	localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_ROW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_COL = 2'd1;
	localparam logic [ROW_W-1:0]     GOAL_ROW_RST = 3'd7;
	localparam logic [ROW_W-1:0]     GOAL_COL_RST = 3'd7;

	// item actions
	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	// neighbor order of the search
	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_RIGHT = 2'd3
	} dir_t;

	typedef struct packed {
		logic             action;
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] col;
		logic             wall;
	} item_t;

	typedef struct packed {
		logic             found;
		logic [CNT_W-1:0] cells_examined;
	} result_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] col;
	} goal_t;

	typedef struct packed {
		logic              ok;
		logic [CELL_W-1:0] addr;
	} nbr_t;

endpackage

// ----- hdl/gmdfs_cfg.sv -----
// goal cell registers of the maze search unit
// depends on gmdfs_pkg
module gmdfs_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr,
	input  logic [gmdfs_pkg::CFG_IDX_W-1:0]     index,
	input  logic [gmdfs_pkg::CFG_DATA_W-1:0]    data,
	output gmdfs_pkg::goal_t                    goal
);

	gmdfs_pkg::goal_t goal_q;

	// register decode; writes to other indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_q.row <= gmdfs_pkg::GOAL_ROW_RST;
			goal_q.col <= gmdfs_pkg::GOAL_COL_RST;
		end else if (wr) begin
			if (index == gmdfs_pkg::REG_GOAL_ROW) begin
				goal_q.row <= data[gmdfs_pkg::ROW_W-1:0];
			end
			if (index == gmdfs_pkg::REG_GOAL_COL) begin
				goal_q.col <= data[gmdfs_pkg::ROW_W-1:0];
			end
		end
	end

	assign goal = goal_q;

endmodule

// ----- hdl/gmdfs_nbr.sv -----
// neighbor cell generator: steps one cell up, down, left or right
// depends on gmdfs_pkg
module gmdfs_nbr (
	input  logic [gmdfs_pkg::CELL_W-1:0] pos,
	input  gmdfs_pkg::dir_t              dir,
	output gmdfs_pkg::nbr_t              nbr
);

	localparam logic [gmdfs_pkg::ROW_W-1:0] EDGE_HI = gmdfs_pkg::ROW_W'(gmdfs_pkg::GRID_SIZE - 1);
	localparam logic [gmdfs_pkg::ROW_W-1:0] ONE     = gmdfs_pkg::ROW_W'(1);

	logic [gmdfs_pkg::ROW_W-1:0] r;
	logic [gmdfs_pkg::ROW_W-1:0] c;
	logic [gmdfs_pkg::ROW_W-1:0] nr;
	logic [gmdfs_pkg::ROW_W-1:0] nc;
	logic                        ok;

	assign r = pos[gmdfs_pkg::CELL_W-1:gmdfs_pkg::ROW_W];
	assign c = pos[gmdfs_pkg::ROW_W-1:0];

	// step and grid-edge check
	always_comb begin
		nr = r;
		nc = c;
		ok = 1'b0;
		unique case (dir)
			gmdfs_pkg::DIR_UP: begin
				nr = r - ONE;
				ok = (r != '0);
			end
			gmdfs_pkg::DIR_DOWN: begin
				nr = r + ONE;
				ok = (r != EDGE_HI);
			end
			gmdfs_pkg::DIR_LEFT: begin
				nc = c - ONE;
				ok = (c != '0);
			end
			gmdfs_pkg::DIR_RIGHT: begin
				nc = c + ONE;
				ok = (c != EDGE_HI);
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	assign nbr.ok   = ok;
	assign nbr.addr = {nr, nc};

endmodule

// ----- hdl/grid_maze_dfs_search_unit.sv -----
// Grid maze depth-first search unit: load items write wall bits, search items
// run a stack search from a start cell toward the goal cell.
// A load gives no result and leaves busy low. A search keeps busy high while it
// clears the visited bit of every cell, pushes the start cell, and for each popped cell
// reads the stack, checks the cell and, unless it is the goal, its four neighbors;
// it ends on a popped goal or on an empty stack, and the result strobe follows.
// Reset clears the controller and sets the goal to row 7, column 7; the wall
// map holds nothing until loaded. The receiver cannot stall the result.
// depends on gmdfs_pkg, gmdfs_cfg, gmdfs_nbr
module grid_maze_dfs_search_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  gmdfs_pkg::item_t                  item,
	output logic                              done,
	output gmdfs_pkg::result_t                result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gmdfs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gmdfs_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CELL_W  = gmdfs_pkg::CELL_W;
	localparam int DEPTH_W = gmdfs_pkg::DEPTH_W;
	localparam int CNT_W   = gmdfs_pkg::CNT_W;
	localparam logic [CELL_W-1:0]  CLR_LAST  = CELL_W'(gmdfs_pkg::CELL_COUNT - 1);
	localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);
	localparam int MAP_WALL = 1;
	localparam int MAP_VIS  = 0;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CLEAR = 6'b000010,
		S_START = 6'b000100,
		S_POP   = 6'b001000,
		S_CELL  = 6'b010000,
		S_NBR   = 6'b100000
	} state_t;

	state_t                 state_q;
	logic [DEPTH_W-1:0]     depth_q;
	logic [CELL_W-1:0]      clr_q;
	logic [CELL_W-1:0]      start_cell_q;
	logic [CNT_W-1:0]       count_q;
	gmdfs_pkg::dir_t        dir_q;
	gmdfs_pkg::nbr_t        nb_q;
	logic                   done_q;
	gmdfs_pkg::result_t     result_q;

	gmdfs_pkg::goal_t       goal;
	gmdfs_pkg::dir_t        dir_sel;
	gmdfs_pkg::nbr_t        nbr;
	logic [CNT_W-1:0]       cnt_inc;
	logic                   accept;
	logic                   goal_hit;
	logic                   nb_open;

	// map memory: wall bit and visited bit per cell, bit write enables
	logic [1:0]             map_mem [gmdfs_pkg::CELL_COUNT];
	logic [1:0]             map_rd_q;
	logic                   map_re;
	logic [CELL_W-1:0]      map_ra;
	logic                   map_we_wall;
	logic                   map_we_vis;
	logic [CELL_W-1:0]      map_wa;
	logic                   map_wd_vis;

	// stack memory of cell indexes
	logic [CELL_W-1:0]      stack_mem [gmdfs_pkg::CELL_COUNT];
	logic [CELL_W-1:0]      stack_rd_q;
	logic                   stack_re;
	logic [CELL_W-1:0]      stack_ra;
	logic                   stack_we;
	logic [CELL_W-1:0]      stack_wa;
	logic [CELL_W-1:0]      stack_wd;

	gmdfs_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg_valid && cfg_ready),
		.index  (cfg_index),
		.data   (cfg_data),
		.goal   (goal)
	);

	// first neighbor comes from the cell step, the rest follow the direction order
	assign dir_sel = (state_q == S_CELL) ? gmdfs_pkg::DIR_UP
	                                     : gmdfs_pkg::dir_t'(dir_q + 2'd1);

	gmdfs_nbr u_nbr (
		.pos  (stack_rd_q),
		.dir  (dir_sel),
		.nbr  (nbr)
	);

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;
	assign cnt_inc   = (count_q == gmdfs_pkg::CNT_MAX) ? count_q : count_q + 1'b1;
	assign goal_hit  = (stack_rd_q == {goal.row, goal.col});
	assign nb_open   = nb_q.ok && !map_rd_q[MAP_WALL] && !map_rd_q[MAP_VIS];

	// memory port control
	always_comb begin
		map_re      = 1'b0;
		map_ra      = nbr.addr;
		map_we_wall = 1'b0;
		map_we_vis  = 1'b0;
		map_wa      = clr_q;
		map_wd_vis  = 1'b0;
		stack_re    = 1'b0;
		stack_ra    = depth_q[CELL_W-1:0] - 1'b1;
		stack_we    = 1'b0;
		stack_wa    = depth_q[CELL_W-1:0];
		stack_wd    = nb_q.addr;
		unique case (state_q)
			S_IDLE: begin
				map_wa      = {item.row, item.col};
				map_we_wall = accept && (item.action == gmdfs_pkg::ACT_LOAD);
			end
			S_CLEAR: begin
				map_we_vis = 1'b1;
			end
			S_START: begin
				map_wa     = start_cell_q;
				map_we_vis = 1'b1;
				map_wd_vis = 1'b1;
				stack_we   = 1'b1;
				stack_wa   = '0;
				stack_wd   = start_cell_q;
			end
			S_POP: begin
				stack_re = (depth_q != '0);
			end
			S_CELL: begin
				map_re = !goal_hit;
			end
			S_NBR: begin
				map_re     = (dir_q != gmdfs_pkg::DIR_RIGHT);
				map_wa     = nb_q.addr;
				map_we_vis = nb_open;
				map_wd_vis = 1'b1;
				stack_we   = nb_open;
			end
			default: begin
				map_re = 1'b0;
			end
		endcase
	end

	// map memory
	always_ff @(posedge clk) begin
		if (map_we_wall) begin
			map_mem[map_wa][MAP_WALL] <= item.wall;
		end
		if (map_we_vis) begin
			map_mem[map_wa][MAP_VIS] <= map_wd_vis;
		end
		if (map_re) begin
			map_rd_q <= map_mem[map_ra];
		end
	end

	// stack memory
	always_ff @(posedge clk) begin
		if (stack_we) begin
			stack_mem[stack_wa] <= stack_wd;
		end
		if (stack_re) begin
			stack_rd_q <= stack_mem[stack_ra];
		end
	end

	// search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			depth_q <= '0;
			clr_q   <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && (item.action == gmdfs_pkg::ACT_SEARCH)) begin
						start_cell_q <= {item.row, item.col};
						clr_q        <= '0;
						count_q      <= '0;
						state_q      <= S_CLEAR;
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					depth_q <= DEPTH_ONE;
					state_q <= S_POP;
				end
				S_POP: begin
					if (depth_q == '0) begin
						result_q.found          <= 1'b0;
						result_q.cells_examined <= count_q;
						done_q                  <= 1'b1;
						state_q                 <= S_IDLE;
					end else begin
						depth_q <= depth_q - DEPTH_ONE;
						state_q <= S_CELL;
					end
				end
				S_CELL: begin
					count_q <= cnt_inc;
					if (goal_hit) begin
						result_q.found          <= 1'b1;
						result_q.cells_examined <= cnt_inc;
						done_q                  <= 1'b1;
						state_q                 <= S_IDLE;
					end else begin
						nb_q    <= nbr;
						dir_q   <= gmdfs_pkg::DIR_UP;
						state_q <= S_NBR;
					end
				end
				S_NBR: begin
					if (nb_open) begin
						depth_q <= depth_q + DEPTH_ONE;
					end
					if (dir_q == gmdfs_pkg::DIR_RIGHT) begin
						state_q <= S_POP;
					end else begin
						nb_q  <= nbr;
						dir_q <= dir_sel;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// a result only follows a running search
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a running search");

	// the stack never holds more cells than the grid has
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(gmdfs_pkg::CELL_COUNT))
		else $error("stack depth beyond grid size");

	// every search pops at least its start cell and at most every cell once
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.cells_examined != '0) &&
		         (result.cells_examined <= CNT_W'(gmdfs_pkg::CELL_COUNT)))
		else $error("popped cell count out of range");

	// a push only happens while the stack has room
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		stack_we |-> (depth_q < DEPTH_W'(gmdfs_pkg::CELL_COUNT)))
		else $error("push onto a full stack");

endmodule

// ----- verif/grid_maze_dfs_search_unit_checker.sv -----
// checker of the grid maze depth-first search unit: tracks wall map and goal,
// predicts each search result and compares every result strobe with it
// depends on gmdfs_pkg
module grid_maze_dfs_search_unit_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  gmdfs_pkg::item_t                  item,
	input  logic                              done,
	input  gmdfs_pkg::result_t                result,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [gmdfs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gmdfs_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                                errors,
	output int                                pending,
	output int                                found_count
);

	// shadow copy of the block state
	logic                        wall_bits [gmdfs_pkg::CELL_COUNT];
	logic [gmdfs_pkg::ROW_W-1:0] goal_row;
	logic [gmdfs_pkg::ROW_W-1:0] goal_col;
	gmdfs_pkg::result_t          search_q [$];
	gmdfs_pkg::result_t          oldest;
	int                          err_cnt;
	int                          hit_cnt;

	// stack search over the shadow wall map toward the current goal
	function automatic gmdfs_pkg::result_t dfs_search(
			input logic [gmdfs_pkg::ROW_W-1:0] sr,
			input logic [gmdfs_pkg::ROW_W-1:0] sc);
		logic                         seen [gmdfs_pkg::CELL_COUNT];
		logic [gmdfs_pkg::CELL_W-1:0] cell_stk [gmdfs_pkg::CELL_COUNT];
		logic [gmdfs_pkg::CELL_W-1:0] cur;
		int                           depth;
		int                           popped;
		logic                         hit;
		int                           r, c, nr, nc, k;
		gmdfs_pkg::result_t           res;
		for (int i = 0; i < gmdfs_pkg::CELL_COUNT; i++)
			seen[i] = 1'b0;
		seen[{sr, sc}] = 1'b1;
		cell_stk[0] = {sr, sc};
		depth = 1;
		popped = 0;
		hit = 1'b0;
		while (depth > 0 && !hit) begin
			depth--;
			cur = cell_stk[depth];
			if (popped < gmdfs_pkg::CNT_MAX)
				popped++;
			r = cur / gmdfs_pkg::GRID_SIZE;
			c = cur % gmdfs_pkg::GRID_SIZE;
			if (r == goal_row && c == goal_col) begin
				hit = 1'b1;
			end else begin
				// neighbors in the order up, down, left, right
				for (k = 0; k < 4; k++) begin
					nr = r;
					nc = c;
					case (gmdfs_pkg::dir_t'(k[1:0]))
						gmdfs_pkg::DIR_UP:    nr = r - 1;
						gmdfs_pkg::DIR_DOWN:  nr = r + 1;
						gmdfs_pkg::DIR_LEFT:  nc = c - 1;
						gmdfs_pkg::DIR_RIGHT: nc = c + 1;
						default: ;
					endcase
					if (nr >= 0 && nr < gmdfs_pkg::GRID_SIZE &&
					    nc >= 0 && nc < gmdfs_pkg::GRID_SIZE) begin
						if (!wall_bits[nr * gmdfs_pkg::GRID_SIZE + nc] &&
						    !seen[nr * gmdfs_pkg::GRID_SIZE + nc]) begin
							seen[nr * gmdfs_pkg::GRID_SIZE + nc] = 1'b1;
							cell_stk[depth] =
								gmdfs_pkg::CELL_W'(nr * gmdfs_pkg::GRID_SIZE + nc);
							depth++;
						end
					end
				end
			end
		end
		res.found = hit;
		res.cells_examined = gmdfs_pkg::CNT_W'(popped);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_row = gmdfs_pkg::GOAL_ROW_RST;
			goal_col = gmdfs_pkg::GOAL_COL_RST;
			search_q.delete();
			err_cnt = 0;
			hit_cnt = 0;
			errors <= 0;
			pending <= 0;
			found_count <= 0;
		end else begin
			// result transfer against the oldest open search
			if (done) begin
				if (search_q.size() == 0) begin
					$display("%0t: result with no search pending: found %0d cells %0d",
						$time, result.found, result.cells_examined);
					err_cnt++;
				end else begin
					oldest = search_q.pop_front();
					if (result.found !== oldest.found) begin
						$display("%0t: found mismatch: expected %0d actual %0d",
							$time, oldest.found, result.found);
						err_cnt++;
					end
					if (result.cells_examined !== oldest.cells_examined) begin
						$display("%0t: cells_examined mismatch: expected %0d actual %0d",
							$time, oldest.cells_examined, result.cells_examined);
						err_cnt++;
					end
					if (oldest.found)
						hit_cnt++;
				end
			end
			// register write transfer
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					gmdfs_pkg::REG_GOAL_ROW: goal_row = cfg_data;
					gmdfs_pkg::REG_GOAL_COL: goal_col = cfg_data;
					default: ;
				endcase
			end
			// item transfer
			if (start && !busy) begin
				if (item.action == gmdfs_pkg::ACT_LOAD)
					wall_bits[{item.row, item.col}] = item.wall;
				else
					search_q.push_back(dfs_search(item.row, item.col));
			end
			errors <= err_cnt;
			pending <= search_q.size();
			found_count <= hit_cnt;
		end
	end

endmodule

// ----- verif/grid_maze_dfs_search_unit_tb.sv -----
// top of the grid maze search unit testbench: clock, reset, maze loads,
// searches and goal writes with random gaps; verdict from the checker
// depends on gmdfs_pkg, grid_maze_dfs_search_unit, grid_maze_dfs_search_unit_checker
module grid_maze_dfs_search_unit_tb;

	localparam int ITEM_TARGET    = 1000;
	localparam int GAP_PCT        = 23;
	localparam int QUIET_FIRST    = 400;
	localparam int QUIET_LAST     = 650;
	localparam int LOAD_SETTLE    = 4;
	localparam int SEARCH_DRAIN   = 480;
	localparam int TIMEOUT_CYCLES = 3_000_000;

	// indexes that select no register
	localparam logic [gmdfs_pkg::CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
	localparam logic [gmdfs_pkg::CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

	logic                             clk;
	logic                             arst_n;
	logic                             start;
	logic                             busy;
	gmdfs_pkg::item_t                 item;
	logic                             done;
	gmdfs_pkg::result_t               result;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [gmdfs_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [gmdfs_pkg::CFG_DATA_W-1:0] cfg_data;
	int                               errors;
	int                               pending;
	int                               found_count;

	int                          n_items;
	int                          n_loads;
	int                          n_searches;
	int                          n_writes;
	logic [gmdfs_pkg::ROW_W-1:0] goal_r;
	logic [gmdfs_pkg::ROW_W-1:0] goal_c;

	grid_maze_dfs_search_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	grid_maze_dfs_search_unit_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.done        (done),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.pending     (pending),
		.found_count (found_count)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	initial begin
		#(TIMEOUT_CYCLES * 10);
		$display("simulation failed");
		$finish;
	end

	// random sender gaps, none in the quiet stretch
	function automatic bit take_gap();
		if (n_items >= QUIET_FIRST && n_items < QUIET_LAST)
			return 1'b0;
		return $urandom_range(0, 99) < GAP_PCT;
	endfunction

	// one item transfer; start stays high so the next item may follow at once
	task automatic push_item(input gmdfs_pkg::item_t it);
		while (take_gap()) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		n_items++;
		if (it.action == gmdfs_pkg::ACT_LOAD)
			n_loads++;
		else
			n_searches++;
	endtask

	task automatic send_load(input int r, input int c, input bit w);
		gmdfs_pkg::item_t it;
		it.action = gmdfs_pkg::ACT_LOAD;
		it.row = gmdfs_pkg::ROW_W'(r);
		it.col = gmdfs_pkg::ROW_W'(c);
		it.wall = w;
		push_item(it);
	endtask

	// wall bit of a search is don't-care, so it toggles at random
	task automatic send_search(input int r, input int c);
		gmdfs_pkg::item_t it;
		it.action = gmdfs_pkg::ACT_SEARCH;
		it.row = gmdfs_pkg::ROW_W'(r);
		it.col = gmdfs_pkg::ROW_W'(c);
		it.wall = 1'($urandom_range(0, 1));
		push_item(it);
	endtask

	// one register write transfer
	task automatic write_reg(input logic [gmdfs_pkg::CFG_IDX_W-1:0] idx,
			input logic [gmdfs_pkg::CFG_DATA_W-1:0] data);
		while (take_gap())
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		n_writes++;
		if (idx == gmdfs_pkg::REG_GOAL_ROW)
			goal_r = data;
		else if (idx == gmdfs_pkg::REG_GOAL_COL)
			goal_c = data;
	endtask

	task automatic set_goal(input int r, input int c);
		write_reg(gmdfs_pkg::REG_GOAL_ROW, gmdfs_pkg::CFG_DATA_W'(r));
		write_reg(gmdfs_pkg::REG_GOAL_COL, gmdfs_pkg::CFG_DATA_W'(c));
	endtask

	// drop start, let every search finish and a trailing load settle
	task automatic wait_idle();
		start <= 1'b0;
		repeat (2)
			@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (LOAD_SETTLE)
			@(posedge clk);
	endtask

	initial begin
		int density;
		int cnt;
		gmdfs_pkg::item_t noise;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		n_items = 0;
		n_loads = 0;
		n_searches = 0;
		n_writes = 0;
		goal_r = gmdfs_pkg::GOAL_ROW_RST;
		goal_c = gmdfs_pkg::GOAL_COL_RST;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// open every cell so no search reads an unwritten wall bit
		for (int r = 0; r < gmdfs_pkg::GRID_SIZE; r++)
			for (int c = 0; c < gmdfs_pkg::GRID_SIZE; c++)
				send_load(r, c, 1'b0);

		// directed: start on goal, open maze, start on a wall
		send_search(7, 7);
		send_search(0, 0);
		send_load(0, 0, 1'b1);
		send_search(0, 0);
		// goal sealed off: from outside every reachable cell popped, not found; from the goal, found
		send_load(6, 7, 1'b1);
		send_load(7, 6, 1'b1);
		send_search(0, 0);
		send_search(7, 7);
		// goal at the low corner, itself a wall
		wait_idle();
		set_goal(0, 0);
		send_search(7, 7);
		send_search(0, 0);
		// writes to unused indexes change nothing
		wait_idle();
		write_reg(REG_UNUSED_A, 3'd5);
		write_reg(REG_UNUSED_B, 3'd7);
		send_search(3, 4);
		wait_idle();
		set_goal(0, 7);
		send_search(7, 0);
		wait_idle();
		set_goal(7, 0);
		send_search(0, 7);
		send_load(0, 0, 1'b0);
		send_load(6, 7, 1'b0);
		send_load(7, 6, 1'b0);
		send_search(4, 4);

		// random phases: goal change, maze edits, searches
		while (n_items < ITEM_TARGET) begin
			wait_idle();
			case ($urandom_range(0, 5))
				0: set_goal(0, 0);
				1: set_goal(7, 7);
				2: set_goal($urandom_range(0, 7), $urandom_range(0, 7));
				3: write_reg(gmdfs_pkg::REG_GOAL_ROW,
					gmdfs_pkg::CFG_DATA_W'($urandom_range(0, 7)));
				4: write_reg(gmdfs_pkg::REG_GOAL_COL,
					gmdfs_pkg::CFG_DATA_W'($urandom_range(0, 7)));
				default: begin
					write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B,
						gmdfs_pkg::CFG_DATA_W'($urandom_range(0, 7)));
					set_goal($urandom_range(0, 7), $urandom_range(0, 7));
				end
			endcase
			case ($urandom_range(0, 5))
				0: density = 0;
				1: density = 10;
				2: density = 25;
				3: density = 40;
				4: density = 60;
				default: density = 85;
			endcase
			// maze edits: now and then a whole new maze
			if ($urandom_range(0, 7) == 0) begin
				for (int r = 0; r < gmdfs_pkg::GRID_SIZE; r++)
					for (int c = 0; c < gmdfs_pkg::GRID_SIZE; c++)
						send_load(r, c, $urandom_range(0, 99) < density);
			end else begin
				cnt = $urandom_range(1, 12);
				repeat (cnt)
					send_load($urandom_range(0, 7), $urandom_range(0, 7),
						$urandom_range(0, 99) < density);
			end
			// noise burst of fully random items
			if ($urandom_range(0, 4) == 0) begin
				cnt = $urandom_range(1, 8);
				repeat (cnt) begin
					noise = gmdfs_pkg::item_t'(8'($urandom_range(0, 255)));
					push_item(noise);
				end
			end
			cnt = $urandom_range(1, 4);
			repeat (cnt) begin
				if ($urandom_range(0, 5) == 0)
					send_search(goal_r, goal_c);
				else
					send_search($urandom_range(0, 7), $urandom_range(0, 7));
			end
		end

		// drain
		start <= 1'b0;
		repeat (2)
			@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SEARCH_DRAIN)
			@(posedge clk);

		$display("covered %0d maze loads and %0d searches, %0d of them reaching the goal,",
			n_loads, n_searches, found_count);
		$display("with %0d register writes across goal corners and unused indexes", n_writes);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
